>>> hw/rtl/mcn_pkg.sv
// Shared types, constants and lookup functions of the mecanum odometry unit.
`default_nettype none

package mcn_pkg;

    localparam int COUNT_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int STEP_W           = 5;

    // Datapath widths: shared multiplier operands, product and accumulator.
    localparam int MA_W  = 34;
    localparam int MB_W  = 32;
    localparam int PW    = MA_W + MB_W;
    localparam int ACC_W = 68;
    localparam int ANG_W = 42;
    localparam int CW    = 34;

    localparam logic signed [63:0] TWO_PI32    = 64'sd26986075409;
    localparam logic signed [63:0] PI32        = 64'sd13493037705;
    localparam logic signed [63:0] HALF_PI32   = 64'sd6746518852;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
    localparam logic signed [63:0] DELTA_LIM   = 64'sd274877906944;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

    // Configuration register indexes and reset values.
    localparam logic [2:0] REG_DIST  = 3'd0;
    localparam logic [2:0] REG_INV   = 3'd1;
    localparam logic [2:0] REG_ALPHA = 3'd2;
    localparam logic [2:0] REG_TPS   = 3'd3;
    localparam logic [2:0] REG_ZBAND = 3'd4;

    localparam logic [23:0] DIST_RST  = 24'd18300;
    localparam logic [23:0] INV_RST   = 24'd79922;
    localparam logic [16:0] ALPHA_RST = 17'd19661;
    localparam logic [13:0] TPS_RST   = 14'd50;
    localparam logic [15:0] ZBAND_RST = 16'd66;

    typedef struct packed {
        logic       operation;
        logic [1:0] wheel;
        logic       phase_b;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_turn;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
    } result_t;

    typedef struct packed {
        logic [23:0] dist_tick;
        logic [23:0] inv;
        logic [16:0] alpha;
        logic [13:0] tps;
        logic [15:0] zband;
    } cfg_t;

    typedef logic [3:0] msel_t;
    localparam msel_t MS_NONE = 4'd0;
    localparam msel_t MS_DHI  = 4'd1;
    localparam msel_t MS_DLO  = 4'd2;
    localparam msel_t MS_WZ   = 4'd3;
    localparam msel_t MS_VXC  = 4'd4;
    localparam msel_t MS_VYS  = 4'd5;
    localparam msel_t MS_VXS  = 4'd6;
    localparam msel_t MS_VYC  = 4'd7;
    localparam msel_t MS_VT   = 4'd8;
    localparam msel_t MS_NEWA = 4'd9;
    localparam msel_t MS_OLD  = 4'd10;

    typedef logic [2:0] aop_t;
    localparam aop_t AC_NONE   = 3'd0;
    localparam aop_t AC_LOAD   = 3'd1;
    localparam aop_t AC_LOADSH = 3'd2;
    localparam aop_t AC_ADD    = 3'd3;
    localparam aop_t AC_SUB    = 3'd4;

    typedef logic [3:0] wb_t;
    localparam wb_t WB_NONE   = 4'd0;
    localparam wb_t WB_TRAVEL = 4'd1;
    localparam wb_t WB_VXY    = 4'd2;
    localparam wb_t WB_WZ     = 4'd3;
    localparam wb_t WB_POSX   = 4'd4;
    localparam wb_t WB_POSY   = 4'd5;
    localparam wb_t WB_FRESH  = 4'd6;
    localparam wb_t WB_SMOOTH = 4'd7;
    localparam wb_t WB_ANG2   = 4'd8;
    localparam wb_t WB_OUT    = 4'd9;

    typedef logic [2:0] cr_t;
    localparam cr_t CR_NONE  = 3'd0;
    localparam cr_t CR_START = 3'd1;
    localparam cr_t CR_RED   = 3'd2;
    localparam cr_t CR_FIN   = 3'd3;
    localparam cr_t CR_FIN2  = 3'd4;
    localparam cr_t CR_ITER  = 3'd5;
    localparam cr_t CR_DONE  = 3'd6;

    typedef struct packed {
        logic              count_en;
        msel_t             msel;
        aop_t              aop;
        wb_t               wb;
        cr_t               cr;
        logic [1:0]        idx;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } stat_t;

    function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [29:0] r;
        case (i)
            5'd0:    r = 30'd843314857;
            5'd1:    r = 30'd497837829;
            5'd2:    r = 30'd263043837;
            5'd3:    r = 30'd133525159;
            5'd4:    r = 30'd67021687;
            5'd5:    r = 30'd33543516;
            5'd6:    r = 30'd16775851;
            5'd7:    r = 30'd8388437;
            5'd8:    r = 30'd4194283;
            5'd9:    r = 30'd2097149;
            5'd10:   r = 30'd1048576;
            5'd11:   r = 30'd524288;
            5'd12:   r = 30'd262144;
            5'd13:   r = 30'd131072;
            5'd14:   r = 30'd65536;
            5'd15:   r = 30'd32768;
            5'd16:   r = 30'd16384;
            5'd17:   r = 30'd8192;
            5'd18:   r = 30'd4096;
            5'd19:   r = 30'd2048;
            5'd20:   r = 30'd1024;
            5'd21:   r = 30'd512;
            5'd22:   r = 30'd256;
            5'd23:   r = 30'd128;
            5'd24:   r = 30'd64;
            5'd25:   r = 30'd32;
            5'd26:   r = 30'd16;
            5'd27:   r = 30'd8;
            5'd28:   r = 30'd4;
            5'd29:   r = 30'd2;
            5'd30:   r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SAT_LO)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcn_ctrl.sv
// Sequencer of the odometry unit: issues one datapath command per cycle.
`default_nettype none

module mcn_ctrl #(
    parameter int CORDIC_STEPS = mcn_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  wire logic          item_tick,
    input  wire mcn_pkg::stat_t stat,
    output mcn_pkg::cmd_t      cmd
);
    import mcn_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WHEEL  = 4'd1;
    localparam logic [3:0] ST_TURN   = 4'd2;
    localparam logic [3:0] ST_CSTART = 4'd3;
    localparam logic [3:0] ST_CRED   = 4'd4;
    localparam logic [3:0] ST_CFIN   = 4'd5;
    localparam logic [3:0] ST_CFIN2  = 4'd6;
    localparam logic [3:0] ST_CITER  = 4'd7;
    localparam logic [3:0] ST_CDONE  = 4'd8;
    localparam logic [3:0] ST_POSE   = 4'd9;
    localparam logic [3:0] ST_SMOOTH = 4'd10;
    localparam logic [3:0] ST_ANG2   = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    localparam logic [STEP_W-1:0] LAST_RED  = STEP_W'(5);
    localparam logic [STEP_W-1:0] LAST_ITER = STEP_W'(CORDIC_STEPS - 1);

    logic [3:0]        state_reg, state_next;
    logic [2:0]        ph_reg, ph_next;
    logic [1:0]        idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              pass_reg, pass_next;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.step   = step_reg;
        item_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_tick)
                    begin
                        state_next = ST_WHEEL;
                        ph_next    = 3'd0;
                        idx_next   = 2'd0;
                    end
                    else
                    begin
                        cmd.count_en = 1'b1;
                    end
                end
            end
            ST_WHEEL:
            begin
                case (ph_reg)
                    3'd0: cmd.msel = MS_DHI;
                    3'd1:
                    begin
                        cmd.aop  = AC_LOADSH;
                        cmd.msel = MS_DLO;
                    end
                    3'd2: cmd.aop = AC_ADD;
                    default: cmd.wb = WB_TRAVEL;
                endcase
                if (ph_reg == 3'd3)
                begin
                    ph_next = 3'd0;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_TURN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_TURN:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        cmd.wb   = WB_VXY;
                        cmd.msel = MS_WZ;
                    end
                    3'd1: cmd.aop = AC_LOAD;
                    default: cmd.wb = WB_WZ;
                endcase
                if (ph_reg == 3'd2)
                begin
                    state_next = ST_CSTART;
                    pass_next  = 1'b0;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_CSTART:
            begin
                cmd.cr     = CR_START;
                state_next = ST_CRED;
                step_next  = '0;
            end
            ST_CRED:
            begin
                cmd.cr = CR_RED;
                if (step_reg == LAST_RED)
                begin
                    state_next = ST_CFIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_CFIN:
            begin
                cmd.cr     = CR_FIN;
                state_next = ST_CFIN2;
            end
            ST_CFIN2:
            begin
                cmd.cr     = CR_FIN2;
                state_next = ST_CITER;
                step_next  = '0;
            end
            ST_CITER:
            begin
                cmd.cr = CR_ITER;
                if (step_reg == LAST_ITER)
                begin
                    state_next = ST_CDONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_CDONE:
            begin
                cmd.cr  = CR_DONE;
                ph_next = 3'd0;
                if (pass_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_POSE;
                end
            end
            ST_POSE:
            begin
                case (ph_reg)
                    3'd0: cmd.msel = MS_VXC;
                    3'd1:
                    begin
                        cmd.aop  = AC_LOAD;
                        cmd.msel = MS_VYS;
                    end
                    3'd2: cmd.aop = AC_SUB;
                    3'd3:
                    begin
                        cmd.wb   = WB_POSX;
                        cmd.msel = MS_VXS;
                    end
                    3'd4:
                    begin
                        cmd.aop  = AC_LOAD;
                        cmd.msel = MS_VYC;
                    end
                    3'd5: cmd.aop = AC_ADD;
                    default: cmd.wb = WB_POSY;
                endcase
                if (ph_reg == 3'd6)
                begin
                    state_next = ST_SMOOTH;
                    ph_next    = 3'd0;
                    idx_next   = 2'd0;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_SMOOTH:
            begin
                case (ph_reg)
                    3'd0: cmd.msel = MS_VT;
                    3'd1: cmd.aop = AC_LOAD;
                    3'd2: cmd.wb = WB_FRESH;
                    3'd3: cmd.msel = MS_NEWA;
                    3'd4:
                    begin
                        cmd.aop  = AC_LOAD;
                        cmd.msel = MS_OLD;
                    end
                    3'd5: cmd.aop = AC_ADD;
                    default: cmd.wb = WB_SMOOTH;
                endcase
                if (ph_reg == 3'd6)
                begin
                    ph_next = 3'd0;
                    if (idx_reg == 2'd2)
                    begin
                        state_next = ST_ANG2;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_ANG2:
            begin
                cmd.wb     = WB_ANG2;
                state_next = ST_CSTART;
                pass_next  = 1'b1;
            end
            ST_OUT:
            begin
                // The result register may still hold an earlier transfer.
                if (!stat.out_full)
                begin
                    cmd.wb     = WB_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= 3'd0;
            idx_reg   <= 2'd0;
            step_reg  <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_tick) |=> !item_ready)
        else $error("tick transfer did not close the input");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wb == WB_OUT) |-> !stat.out_full)
        else $error("result written over a pending transfer");

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CITER) |-> (step_reg <= LAST_ITER))
        else $error("rotation step beyond last");

    a_edge_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_en |-> (item_valid && item_ready && !item_tick))
        else $error("count update without an edge transfer");

endmodule

`default_nettype wire

>>> hw/rtl/mcn_dpath.sv
// Datapath of the odometry unit: counters, shared multiplier, accumulator, CORDIC, pose.
`default_nettype none

module mcn_dpath #(
    parameter int COUNT_BITS = mcn_pkg::COUNT_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mcn_pkg::cmd_t    cmd,
    input  wire mcn_pkg::item_t   item,
    input  wire mcn_pkg::cfg_t    cfg,
    output mcn_pkg::stat_t        stat,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mcn_pkg::result_t      result
);
    import mcn_pkg::*;

    localparam int XW = (COUNT_BITS > 40) ? COUNT_BITS : 40;
    localparam logic signed [XW-1:0]    D_LIM   = XW'(DELTA_LIM);
    localparam logic signed [ANG_W-1:0] A_2PI   = ANG_W'(TWO_PI32);
    localparam logic signed [ANG_W-1:0] A_PI    = ANG_W'(PI32);
    localparam logic signed [ANG_W-1:0] A_HPI   = ANG_W'(HALF_PI32);
    localparam logic signed [CW-1:0]    C_ONE   = CW'(Q30_ONE);
    localparam logic signed [CW-1:0]    C_GAIN  = CW'(CORDIC_GAIN);

    logic [COUNT_BITS-1:0] cnt_reg  [4];
    logic [COUNT_BITS-1:0] last_reg [4];
    logic signed [31:0]    d_reg    [4];
    logic signed [31:0]    sv_reg   [3];
    logic signed [31:0]    pose_x_reg, pose_y_reg, yaw_reg, wz_reg, fresh_reg;
    logic signed [31:0]    sin_reg, cos_reg;
    logic signed [32:0]    vx_reg, vy_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ANG_W-1:0] ang_reg, rr_reg;
    logic                  neg_in_reg, flip_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg, cz_reg;
    result_t               res_reg;
    logic                  res_valid_reg;

    logic [COUNT_BITS-1:0] u;
    logic signed [XW-1:0]  dx, dcl_full;
    logic signed [39:0]    dcl;
    logic signed [33:0]    sumx, sumy, diffsum;
    logic signed [32:0]    vxn, vyn;
    logic [16:0]           alpha_eff, alpha_rem;
    logic signed [MA_W-1:0] ma;
    logic signed [MB_W-1:0] mb;
    logic signed [PW-1:0]  prod;
    logic signed [31:0]    sv_sel;
    logic signed [ACC_W-1:0] r8, r16, r30, mag, zb_ext;
    logic signed [31:0]    wzn;
    logic [2:0]            red_k;
    logic signed [ANG_W-1:0] tk, fm, fr, hr;
    logic                  hflip;
    logic signed [CW-1:0]  xs, ys, at, xf, yf;

    always_comb
    begin
        u        = cnt_reg[cmd.idx] - last_reg[cmd.idx];
        dx       = XW'(signed'(u));
        dcl_full = (dx > D_LIM) ? D_LIM : ((dx < -D_LIM) ? -D_LIM : dx);
        dcl      = dcl_full[39:0];

        sumx    = 34'(d_reg[0]) + 34'(d_reg[1]) + 34'(d_reg[2]) + 34'(d_reg[3]);
        sumy    = -34'(d_reg[0]) + 34'(d_reg[1]) + 34'(d_reg[2]) - 34'(d_reg[3]);
        diffsum = -34'(d_reg[0]) + 34'(d_reg[1]) - 34'(d_reg[2]) + 34'(d_reg[3]);
        vxn     = 33'((sumx + 34'sd2) >>> 2);
        vyn     = 33'((sumy + 34'sd2) >>> 2);

        alpha_eff = (cfg.alpha > 17'd65536) ? 17'd65536 : cfg.alpha;
        alpha_rem = 17'd65536 - alpha_eff;

        case (cmd.idx)
            2'd0:    sv_sel = sv_reg[0];
            2'd1:    sv_sel = sv_reg[1];
            default: sv_sel = sv_reg[2];
        endcase

        ma = '0;
        mb = '0;
        case (cmd.msel)
            MS_DHI:
            begin
                ma = MA_W'(signed'(dcl[39:20]));
                mb = MB_W'(cfg.dist_tick);
            end
            MS_DLO:
            begin
                ma = MA_W'({1'b0, dcl[19:0]});
                mb = MB_W'(cfg.dist_tick);
            end
            MS_WZ:
            begin
                ma = diffsum;
                mb = MB_W'(cfg.inv);
            end
            MS_VXC:
            begin
                ma = MA_W'(vx_reg);
                mb = cos_reg;
            end
            MS_VYS:
            begin
                ma = MA_W'(vy_reg);
                mb = sin_reg;
            end
            MS_VXS:
            begin
                ma = MA_W'(vx_reg);
                mb = sin_reg;
            end
            MS_VYC:
            begin
                ma = MA_W'(vy_reg);
                mb = cos_reg;
            end
            MS_VT:
            begin
                case (cmd.idx)
                    2'd0:    ma = MA_W'(vx_reg);
                    2'd1:    ma = MA_W'(vy_reg);
                    default: ma = MA_W'(wz_reg);
                endcase
                mb = MB_W'(cfg.tps);
            end
            MS_NEWA:
            begin
                ma = MA_W'(fresh_reg);
                mb = MB_W'(alpha_eff);
            end
            MS_OLD:
            begin
                ma = MA_W'(sv_sel);
                mb = MB_W'(alpha_rem);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = ma * mb;

        r8     = (acc_reg + ACC_W'(128)) >>> 8;
        r16    = (acc_reg + ACC_W'(32768)) >>> 16;
        r30    = (acc_reg + ACC_W'(536870912)) >>> 30;
        mag    = (r16 < 0) ? -r16 : r16;
        zb_ext = ACC_W'({1'b0, cfg.zband});
        wzn    = sat32(r8);

        // Angle reduction: subtract 2*pi shifted left by 5 down to 0.
        red_k = 3'(3'd5 - cmd.step[2:0]);
        tk    = A_2PI <<< red_k;
        fm    = (neg_in_reg && (rr_reg != '0)) ? (A_2PI - rr_reg) : rr_reg;
        fr    = (fm > A_PI) ? (fm - A_2PI) : fm;
        if (rr_reg > A_HPI)
        begin
            hr    = rr_reg - A_PI;
            hflip = 1'b1;
        end
        else if (rr_reg < -A_HPI)
        begin
            hr    = rr_reg + A_PI;
            hflip = 1'b1;
        end
        else
        begin
            hr    = rr_reg;
            hflip = 1'b0;
        end

        xs = cx_reg >>> cmd.step;
        ys = cy_reg >>> cmd.step;
        at = CW'(atan_q30(cmd.step));
        xf = flip_reg ? -cx_reg : cx_reg;
        yf = flip_reg ? -cy_reg : cy_reg;
    end

    // Architectural state that the model clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                sv_reg[i] <= '0;
            end
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            yaw_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_en)
            begin
                if (item.phase_b)
                begin
                    cnt_reg[item.wheel] <= cnt_reg[item.wheel] + COUNT_BITS'(1);
                end
                else
                begin
                    cnt_reg[item.wheel] <= cnt_reg[item.wheel] - COUNT_BITS'(1);
                end
            end
            // A new result may be loaded in the cycle the previous one transfers.
            if (cmd.wb == WB_OUT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (cmd.wb)
                WB_TRAVEL: last_reg[cmd.idx] <= cnt_reg[cmd.idx];
                WB_WZ:     yaw_reg <= sat32(ACC_W'(yaw_reg) + ACC_W'(wzn));
                WB_POSX:   pose_x_reg <= sat32(ACC_W'(pose_x_reg) + r30);
                WB_POSY:   pose_y_reg <= sat32(ACC_W'(pose_y_reg) + r30);
                WB_SMOOTH:
                begin
                    case (cmd.idx)
                        2'd0:    sv_reg[0] <= (mag < zb_ext) ? 32'sd0 : sat32(r16);
                        2'd1:    sv_reg[1] <= (mag < zb_ext) ? 32'sd0 : sat32(r16);
                        default: sv_reg[2] <= (mag < zb_ext) ? 32'sd0 : sat32(r16);
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        case (cmd.aop)
            AC_LOAD:   acc_reg <= ACC_W'(prod_reg);
            AC_LOADSH: acc_reg <= ACC_W'(prod_reg) <<< 20;
            AC_ADD:    acc_reg <= acc_reg + ACC_W'(prod_reg);
            AC_SUB:    acc_reg <= acc_reg - ACC_W'(prod_reg);
            default:
            begin
            end
        endcase
        case (cmd.wb)
            WB_TRAVEL: d_reg[cmd.idx] <= sat32(r8);
            WB_VXY:
            begin
                vx_reg <= vxn;
                vy_reg <= vyn;
            end
            WB_WZ:
            begin
                wz_reg  <= wzn;
                ang_reg <= (ANG_W'(yaw_reg) <<< 8) + (ANG_W'(wzn) <<< 7);
            end
            WB_FRESH:  fresh_reg <= (cmd.idx == 2'd2) ? sat32(r8) : sat32(acc_reg);
            WB_ANG2:   ang_reg <= ANG_W'(yaw_reg) <<< 7;
            WB_OUT:
            begin
                res_reg.pos_x    <= pose_x_reg;
                res_reg.pos_y    <= pose_y_reg;
                res_reg.heading  <= yaw_reg;
                res_reg.vel_x    <= sv_reg[0];
                res_reg.vel_y    <= sv_reg[1];
                res_reg.vel_turn <= sv_reg[2];
                res_reg.quat_z   <= sin_reg;
                res_reg.quat_w   <= cos_reg;
            end
            default:
            begin
            end
        endcase
        case (cmd.cr)
            CR_START:
            begin
                neg_in_reg <= ang_reg[ANG_W-1];
                rr_reg     <= ang_reg[ANG_W-1] ? -ang_reg : ang_reg;
            end
            CR_RED:
            begin
                if (rr_reg >= tk)
                begin
                    rr_reg <= rr_reg - tk;
                end
            end
            CR_FIN: rr_reg <= fr;
            CR_FIN2:
            begin
                flip_reg <= hflip;
                cz_reg   <= CW'((hr + ANG_W'(2)) >>> 2);
                cx_reg   <= C_GAIN;
                cy_reg   <= '0;
            end
            CR_ITER:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
            CR_DONE:
            begin
                cos_reg <= 32'((xf > C_ONE) ? C_ONE : ((xf < -C_ONE) ? -C_ONE : xf));
                sin_reg <= 32'((yf > C_ONE) ? C_ONE : ((yf < -C_ONE) ? -C_ONE : yf));
            end
            default:
            begin
            end
        endcase
    end

    assign stat.out_full = res_valid_reg & ~result_ready;
    assign result_valid  = res_valid_reg;
    assign result        = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mecanum_encoder_odometry_unit.sv
// Top level of the mecanum wheel odometry unit: register port, sequencer and datapath.
`default_nettype none

// Encoder edge items are counted in the cycle of their transfer and produce no
// result. A sample tick item closes the input and runs until its result is in the
// output register, through eight wheel partial products and fourteen further
// products on one shared multiplier and two CORDIC passes on one shift-add
// rotator. A result that is not taken holds the unit in its last step before the
// next tick result, with the input closed until the earlier result transfers.
// Registers are written over the APB port at 4*index.
module mecanum_encoder_odometry_unit #(
    parameter int COUNT_BITS   = mcn_pkg::COUNT_BITS_DEF,
    parameter int CORDIC_STEPS = mcn_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire mcn_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mcn_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mcn_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_tick <= DIST_RST;
            cfg_reg.inv       <= INV_RST;
            cfg_reg.alpha     <= ALPHA_RST;
            cfg_reg.tps       <= TPS_RST;
            cfg_reg.zband     <= ZBAND_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_DIST:  cfg_reg.dist_tick <= pwdata[23:0];
                REG_INV:   cfg_reg.inv       <= pwdata[23:0];
                REG_ALPHA: cfg_reg.alpha     <= pwdata[16:0];
                REG_TPS:   cfg_reg.tps       <= pwdata[13:0];
                REG_ZBAND: cfg_reg.zband     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_DIST:  prdata = 32'(cfg_reg.dist_tick);
            REG_INV:   prdata = 32'(cfg_reg.inv);
            REG_ALPHA: prdata = 32'(cfg_reg.alpha);
            REG_TPS:   prdata = 32'(cfg_reg.tps);
            REG_ZBAND: prdata = 32'(cfg_reg.zband);
            default:   prdata = 32'd0;
        endcase
    end

    mcn_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_tick  (item.operation),
        .stat       (stat),
        .cmd        (cmd)
    );

    mcn_dpath #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg          (cfg_reg),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> sim/mecanum_encoder_odometry_unit_tb.sv
// Testbench for the mecanum odometry unit: directed and random edge and tick traffic checked against a predictor.
`timescale 1ns / 100ps

module mecanum_encoder_odometry_unit_tb;
    import mcn_pkg::*;

    localparam int RUN_LIMIT = 600000;
    localparam int SETTLE    = 200;
    localparam int HOLD_LEN  = 700;
    localparam int NPHASE    = 8;

    localparam longint ANG_2PI  = 64'sd26986075409;
    localparam longint ANG_PI   = 64'sd13493037705;
    localparam longint ANG_HPI  = 64'sd6746518852;
    localparam longint ROT_GAIN = 64'sd652032874;
    localparam longint UNIT_Q30 = 64'sd1073741824;

    localparam longint ARCTAN [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    mecanum_encoder_odometry_unit dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the unit's state and registers.
    logic [31:0] enc_count [4];
    logic [31:0] enc_seen [4];
    longint pose_xp, pose_yp, yaw_p, svx_p, svy_p, swz_p;
    logic [23:0] cfg_dist;
    logic [23:0] cfg_inv;
    logic [16:0] cfg_alpha;
    logic [13:0] cfg_tps;
    logic [15:0] cfg_zband;

    item_t pending_items [$];
    result_t expected_poses [$];
    item_t cur_item;
    int cycles;
    int errors;
    int ticks_sent;
    int edges_sent;
    int poses_checked;
    int hold_left;
    bit hold_done;

    function automatic longint sat_i32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void rotate_angle(longint ang, output longint sn, output longint cs);
        longint r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit flip;
        r = ang % ANG_2PI;
        x = ROT_GAIN;
        y = 0;
        flip = 0;
        if (r < 0)
        begin
            r += ANG_2PI;
        end
        if (r > ANG_PI)
        begin
            r -= ANG_2PI;
        end
        if (r > ANG_HPI)
        begin
            r -= ANG_PI;
            flip = 1;
        end
        else if (r < -ANG_HPI)
        begin
            r += ANG_PI;
            flip = 1;
        end
        z = round_shift(r, 2);
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= ARCTAN[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += ARCTAN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = (x > UNIT_Q30) ? UNIT_Q30 : ((x < -UNIT_Q30) ? -UNIT_Q30 : x);
        sn = (y > UNIT_Q30) ? UNIT_Q30 : ((y < -UNIT_Q30) ? -UNIT_Q30 : y);
    endfunction

    function automatic longint smooth_vel(longint old, longint fresh);
        longint a;
        longint s;
        a = (cfg_alpha > 17'd65536) ? 64'sd65536 : longint'(cfg_alpha);
        s = round_shift(a * fresh + (64'sd65536 - a) * old, 16);
        if (((s < 0) ? -s : s) < longint'(cfg_zband))
        begin
            s = 0;
        end
        return sat_i32(s);
    endfunction

    // Advances the predicted odometry by one transfer; returns 1 when a pose is due.
    function automatic bit odom_predict(item_t it, output result_t r);
        longint trav [4];
        longint delta;
        longint vx;
        longint vy;
        longint wz;
        longint mid;
        longint sn;
        longint cs;
        longint tps;
        logic [31:0] diff;
        r = '0;
        if (!it.operation)
        begin
            enc_count[it.wheel] = it.phase_b ? enc_count[it.wheel] + 1 : enc_count[it.wheel] - 1;
            return 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            diff = enc_count[i] - enc_seen[i];
            delta = longint'($signed(diff));
            trav[i] = sat_i32(round_shift(delta * longint'(cfg_dist), 8));
            enc_seen[i] = enc_count[i];
        end
        vx = round_shift(trav[0] + trav[1] + trav[2] + trav[3], 2);
        vy = round_shift(-trav[0] + trav[1] + trav[2] - trav[3], 2);
        wz = sat_i32(round_shift((-trav[0] + trav[1] - trav[2] + trav[3])
            * longint'(cfg_inv), 8));
        mid = yaw_p * 256 + wz * 128;
        yaw_p = sat_i32(yaw_p + wz);
        rotate_angle(mid, sn, cs);
        pose_xp = sat_i32(pose_xp + round_shift(vx * cs - vy * sn, 30));
        pose_yp = sat_i32(pose_yp + round_shift(vx * sn + vy * cs, 30));
        tps = longint'(cfg_tps);
        svx_p = smooth_vel(svx_p, sat_i32(vx * tps));
        svy_p = smooth_vel(svy_p, sat_i32(vy * tps));
        swz_p = smooth_vel(swz_p, sat_i32(round_shift(wz * tps, 8)));
        rotate_angle(yaw_p * 128, sn, cs);
        r.pos_x = 32'(pose_xp);
        r.pos_y = 32'(pose_yp);
        r.heading = 32'(yaw_p);
        r.vel_x = 32'(svx_p);
        r.vel_y = 32'(svy_p);
        r.vel_turn = 32'(swz_p);
        r.quat_z = 32'(sn);
        r.quat_w = 32'(cs);
        return 1;
    endfunction

    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout with %0d poses still expected", expected_poses.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sender and receiver idle at random except in a quiet window with no gaps at all.
    function automatic bit side_idles();
        if (cycles > 3000 && cycles < 9000)
        begin
            return 0;
        end
        return $urandom_range(99) < 9;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t pose;
        bit accepted;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            accepted = item_valid && item_ready;
            if (accepted)
            begin
                if (odom_predict(cur_item, pose))
                begin
                    expected_poses.push_back(pose);
                end
            end
            if (!item_valid || accepted)
            begin
                if (pending_items.size() > 0 && !side_idles())
                begin
                    cur_item = pending_items.pop_front();
                    item_valid <= 1'b1;
                    item <= cur_item;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                poses_checked++;
                if (expected_poses.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected pose transfer: %p", result);
                    end
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (result.pos_x !== want.pos_x || result.pos_y !== want.pos_y
                        || result.heading !== want.heading || result.vel_x !== want.vel_x
                        || result.vel_y !== want.vel_y || result.vel_turn !== want.vel_turn
                        || result.quat_z !== want.quat_z || result.quat_w !== want.quat_w)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("pose %0d mismatch", poses_checked);
                            $display("  expected %p", want);
                            $display("  actual   %p", result);
                        end
                    end
                end
            end
            // One long hold-off so the output backs up and stalls the input.
            if (!hold_done && poses_checked == 30)
            begin
                hold_done <= 1;
                hold_left <= HOLD_LEN;
                result_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= !side_idles();
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DIST: cfg_dist = val[23:0];
            REG_INV: cfg_inv = val[23:0];
            REG_ALPHA: cfg_alpha = val[16:0];
            REG_TPS: cfg_tps = val[13:0];
            REG_ZBAND: cfg_zband = val[15:0];
            default: ;
        endcase
    endtask

    task automatic push_edge(input logic [1:0] w, input logic up);
        item_t it;
        it.operation = 1'b0;
        it.wheel = w;
        it.phase_b = up;
        pending_items.push_back(it);
        edges_sent++;
    endtask

    task automatic push_tick();
        item_t it;
        it.operation = 1'b1;
        it.wheel = 2'($urandom_range(3));
        it.phase_b = 1'($urandom_range(1));
        pending_items.push_back(it);
        ticks_sent++;
    endtask

    // Mostly bursts of edges closed by a tick, with stray items mixed in.
    task automatic push_random(input int n);
        int sent;
        int burst;
        logic [1:0] w;
        logic up;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(1))
                begin
                    push_tick();
                end
                else
                begin
                    push_edge(2'($urandom_range(3)), 1'($urandom_range(1)));
                end
                sent++;
            end
            else
            begin
                burst = $urandom_range(10);
                w = 2'($urandom_range(3));
                up = 1'($urandom_range(1));
                for (int k = 0; k < burst; k++)
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        push_edge(2'($urandom_range(3)), 1'($urandom_range(1)));
                    end
                    else
                    begin
                        push_edge(w, up);
                    end
                end
                push_tick();
                sent += burst + 1;
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_items.size() > 0 || item_valid || expected_poses.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        errors = 0;
        ticks_sent = 0;
        edges_sent = 0;
        poses_checked = 0;
        for (int i = 0; i < 4; i++)
        begin
            enc_count[i] = '0;
            enc_seen[i] = '0;
        end
        pose_xp = 0;
        pose_yp = 0;
        yaw_p = 0;
        svx_p = 0;
        svy_p = 0;
        swz_p = 0;
        cfg_dist = DIST_RST;
        cfg_inv = INV_RST;
        cfg_alpha = ALPHA_RST;
        cfg_tps = TPS_RST;
        cfg_zband = ZBAND_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every wheel forward and three of them backward, an empty tick, back-to-back ticks.
        for (int w = 0; w < 4; w++)
        begin
            push_edge(2'(w), 1'b1);
            push_edge(2'(w), 1'b1);
        end
        push_tick();
        push_tick();
        push_edge(2'd0, 1'b0);
        push_edge(2'd0, 1'b0);
        push_edge(2'd0, 1'b0);
        push_edge(2'd3, 1'b0);
        push_edge(2'd1, 1'b1);
        push_edge(2'd2, 1'b0);
        push_tick();
        push_edge(2'd1, 1'b1);
        push_edge(2'd3, 1'b1);
        push_tick();
        push_tick();
        push_random(100);

        for (int p = 1; p < NPHASE; p++)
        begin
            wait_quiet();
            case (p)
                1:
                begin
                    reg_write(REG_DIST, 32'd16777215);
                    reg_write(REG_INV, 32'd16777215);
                    reg_write(REG_ALPHA, 32'd65536);
                    reg_write(REG_TPS, 32'd10000);
                    reg_write(REG_ZBAND, 32'd0);
                end
                2:
                begin
                    reg_write(REG_DIST, 32'd1);
                    reg_write(REG_INV, 32'd1);
                    reg_write(REG_ALPHA, 32'd0);
                    reg_write(REG_TPS, 32'd1);
                    reg_write(REG_ZBAND, 32'd65535);
                end
                3:
                begin
                    // Alpha beyond one and a zero sample rate.
                    reg_write(REG_DIST, 32'd300000);
                    reg_write(REG_INV, 32'd200000);
                    reg_write(REG_ALPHA, 32'h1FFFF);
                    reg_write(REG_TPS, 32'd0);
                    reg_write(REG_ZBAND, 32'd10);
                end
                4:
                begin
                    // Zero distance and inverse scale, full tick rate, plus writes past the register list.
                    reg_write(REG_DIST, 32'd0);
                    reg_write(REG_INV, 32'd0);
                    reg_write(REG_TPS, 32'h3FFF);
                    reg_write(3'd5, $urandom);
                    reg_write(3'd7, $urandom);
                end
                5:
                begin
                    reg_write(REG_DIST, 32'd5000000);
                    reg_write(REG_INV, 32'd0);
                    reg_write(REG_ALPHA, 32'd40000);
                    reg_write(REG_TPS, 32'd10000);
                end
                default:
                begin
                    // Random values with stray upper bits set.
                    reg_write(REG_DIST, $urandom);
                    reg_write(REG_INV, $urandom);
                    reg_write(REG_ALPHA, $urandom);
                    reg_write(REG_TPS, $urandom);
                    reg_write(REG_ZBAND, $urandom);
                end
            endcase
            push_random(110);
        end
        wait_quiet();

        $display("covered %0d edge and %0d tick transfers over %0d register settings",
            edges_sent, ticks_sent, NPHASE);
        $display("checked %0d pose transfers, %0d mismatches", poses_checked, errors);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Any pose left over is counted by wait_quiet never finishing; leftovers end in a timeout.
endmodule
